// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk outside reset.
`define CT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside reset.
`define CT_NEVER(label, cond, msg) \
    `CT_ASSERT(label, !(cond), msg)

`endif

// ===== hdl/ct_pkg.sv =====
// Types, constants and token functions of the CSV field tokenizer.
package ct_pkg;

    localparam logic [7:0] LF_BYTE        = 8'd10;
    localparam logic [7:0] CR_BYTE        = 8'd13;
    localparam logic [7:0] DEFAULT_DELIM  = 8'd44;
    localparam logic [7:0] DEFAULT_QUOTE  = 8'd34;
    localparam logic [7:0] DEFAULT_ESCAPE = 8'd92;
    localparam int unsigned MAX_TOKENS    = 4;

    localparam logic [1:0] CFG_IDX_DELIM  = 2'd0;
    localparam logic [1:0] CFG_IDX_QUOTE  = 2'd1;
    localparam logic [1:0] CFG_IDX_ESCAPE = 2'd2;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_SKIP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_ESC   = 2'd1,
        HOLD_QUOTE = 2'd2
    } t_hold;

    typedef enum logic [1:0] {
        TOK_DATA = 2'd0,
        TOK_EOF  = 2'd1,
        TOK_EOR  = 2'd2
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] data;
    } t_token;

    typedef struct packed {
        logic [2:0]   count;
        t_token [3:0] tok;
    } t_tok_list;

    typedef struct packed {
        t_mode mode;
        t_hold hold;
    } t_field_st;

    typedef struct packed {
        t_field_st st;
        t_tok_list toks;
    } t_step;

    typedef struct packed {
        logic [7:0] delim;
        logic [7:0] quote;
        logic [7:0] esc;
    } t_cfg;

    // Appends a token; anything beyond the fourth is dropped.
    function automatic t_tok_list tl_push(t_tok_list l, t_tok_kind k, logic [7:0] b);
        t_tok_list r;
        r = l;
        if (l.count < 3'(MAX_TOKENS)) begin
            r.tok[l.count[1:0]].kind = k;
            r.tok[l.count[1:0]].data = b;
            r.count = l.count + 3'd1;
        end
        return r;
    endfunction

    // A byte inside a field with nothing held: it may terminate the field.
    function automatic t_step plain_char(t_step s, logic [7:0] c, t_cfg cfg);
        t_step r;
        r = s;
        if (s.st.mode == MODE_QUOTED) begin
            if (c == cfg.quote) begin
                r.toks    = tl_push(s.toks, TOK_EOF, 8'h00);
                r.st.mode = MODE_SKIP;
            end else begin
                r.toks = tl_push(s.toks, TOK_DATA, c);
            end
        end else begin
            if (c == cfg.delim) begin
                r.toks    = tl_push(s.toks, TOK_EOF, 8'h00);
                r.st.mode = MODE_START;
            end else begin
                r.toks = tl_push(s.toks, TOK_DATA, c);
            end
        end
        return r;
    endfunction

    // A byte taken with no byte held back.
    function automatic t_step fresh_char(t_step s, logic [7:0] c, t_cfg cfg);
        t_step r;
        r = s;
        if (s.st.mode == MODE_SKIP) begin
            if (c == cfg.delim) begin
                r.st.mode = MODE_START;
            end
        end else if (s.st.mode == MODE_START && c == cfg.quote) begin
            r.st.mode = MODE_QUOTED;
        end else begin
            if (s.st.mode == MODE_START) begin
                r.st.mode = MODE_PLAIN;
            end
            if (c == cfg.esc) begin
                r.st.hold = HOLD_ESC;
            end else if (c == cfg.quote) begin
                r.st.hold = HOLD_QUOTE;
            end else begin
                r = plain_char(r, c, cfg);
            end
        end
        return r;
    endfunction

    // One byte of a row after the row split and CR handling.
    function automatic t_step take_char(t_step s, logic [7:0] c, t_cfg cfg);
        t_step r;
        r = s;
        case (s.st.hold)
            HOLD_ESC: begin
                r.st.hold = HOLD_NONE;
                r.toks    = tl_push(s.toks, TOK_DATA, c);
            end
            HOLD_QUOTE: begin
                r.st.hold = HOLD_NONE;
                if (c == cfg.quote) begin
                    r.toks = tl_push(s.toks, TOK_DATA, cfg.quote);
                end else begin
                    r = plain_char(r, cfg.quote, cfg);
                    r = fresh_char(r, c, cfg);
                end
            end
            default: begin
                r = fresh_char(s, c, cfg);
            end
        endcase
        return r;
    endfunction

    // Closes the row: a held byte becomes plain, an open field is ended.
    function automatic t_step row_end(t_step s, t_cfg cfg);
        t_step      r;
        logic [7:0] x;
        r = s;
        x = (s.st.hold == HOLD_ESC) ? cfg.esc : cfg.quote;
        if (s.st.hold != HOLD_NONE) begin
            r.st.hold = HOLD_NONE;
            r = plain_char(r, x, cfg);
        end
        if (r.st.mode == MODE_PLAIN || r.st.mode == MODE_QUOTED) begin
            r.toks = tl_push(r.toks, TOK_EOF, 8'h00);
        end
        r.toks    = tl_push(r.toks, TOK_EOR, 8'h00);
        r.st.mode = MODE_START;
        return r;
    endfunction

endpackage

// ===== hdl/ct_core.sv =====
// Row and field state of the tokenizer and the token list of one item.
`include "assert_macros.svh"

module ct_core import ct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_kind,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_tok_list  o_toks
);

    t_mode r_mode, n_mode;
    t_hold r_hold, n_hold;
    logic  r_parity, n_parity;
    logic  r_cr, n_cr;
    logic  r_row_open, n_row_open;

    t_step s;

    always_comb begin
        s.st.mode  = r_mode;
        s.st.hold  = r_hold;
        s.toks     = '0;
        n_parity   = r_parity;
        n_cr       = r_cr;
        n_row_open = r_row_open;
        if (i_kind) begin
            // End of input: flush an unfinished row, then return to reset state.
            if (r_row_open || r_cr) begin
                if (r_cr) begin
                    s = take_char(s, CR_BYTE, i_cfg);
                end
                s = row_end(s, i_cfg);
            end
            n_parity   = 1'b0;
            n_cr       = 1'b0;
            n_row_open = 1'b0;
            n_mode     = MODE_START;
            n_hold     = HOLD_NONE;
        end else begin
            if (i_byte == LF_BYTE && i_byte != i_cfg.quote && !r_parity) begin
                s          = row_end(s, i_cfg);
                n_parity   = 1'b0;
                n_cr       = 1'b0;
                n_row_open = 1'b0;
            end else begin
                n_row_open = 1'b1;
                if (r_cr) begin
                    s = take_char(s, CR_BYTE, i_cfg);
                end
                n_parity = r_parity ^ (i_byte == i_cfg.quote);
                n_cr     = (i_byte == CR_BYTE);
                if (i_byte != CR_BYTE) begin
                    s = take_char(s, i_byte, i_cfg);
                end
            end
            n_mode = s.st.mode;
            n_hold = s.st.hold;
        end
    end

    assign o_toks = s.toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_hold     <= HOLD_NONE;
            r_parity   <= 1'b0;
            r_cr       <= 1'b0;
            r_row_open <= 1'b0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_hold     <= n_hold;
            r_parity   <= n_parity;
            r_cr       <= n_cr;
            r_row_open <= n_row_open;
        end
    end

    `CT_ASSERT(a_hold_in_field, (r_hold != HOLD_NONE) |-> (r_mode == MODE_PLAIN || r_mode == MODE_QUOTED), "byte held outside a field")
    `CT_ASSERT(a_eoi_clears, (i_step && i_kind) |=> (r_mode == MODE_START && r_hold == HOLD_NONE && !r_parity && !r_cr && !r_row_open), "end of input left state behind")
    `CT_NEVER(a_tok_count, o_toks.count > 3'(MAX_TOKENS), "token list overflow")

endmodule

// ===== hdl/ct_tokbuf.sv =====
// Result register that hands out the tokens of one item one per cycle while i_tready is high.
`include "assert_macros.svh"

module ct_tokbuf import ct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_tok_list i_toks,
    input  logic      i_tready,
    output logic      o_valid,
    output t_token    o_token,
    output logic      o_last,
    output logic      o_can_load
);

    t_token [3:0] r_tok;
    logic [2:0]   r_count;
    logic [1:0]   r_pos;
    logic         pop;

    assign o_valid    = (r_count != 3'd0);
    assign o_token    = r_tok[r_pos];
    assign o_last     = ({1'b0, r_pos} == (r_count - 3'd1));
    assign pop        = o_valid && i_tready;
    assign o_can_load = !o_valid || (pop && o_last);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_toks.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_pos   <= 2'd0;
        end else if (i_load) begin
            r_count <= i_toks.count;
            r_pos   <= 2'd0;
        end else if (pop) begin
            if (o_last) begin
                r_count <= 3'd0;
                r_pos   <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    `CT_ASSERT(a_pos_in_range, o_valid |-> ({1'b0, r_pos} < r_count), "read position past token count")
    `CT_ASSERT(a_load_shows, (i_load && i_toks.count != 3'd0) |=> o_valid, "loaded tokens not presented")
    `CT_ASSERT(a_no_early_end, (pop && !o_last && !i_load) |=> (o_valid && r_pos == $past(r_pos) + 2'd1), "tokens lost mid item")

endmodule

// ===== hdl/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer: input register, tokenizer state and result register.
// An accepted byte passes through the input register and then the result register before its first token shows.
// Input: one transaction per cycle while each item yields at most one token and m_axis_tready is high;
// an item that yields several tokens (up to four) holds the input until its last token is taken.
// Reset (i_rst_n low, synchronous) restores comma, double quote and backslash as
// delimiter, quote and escape, and clears all row and field state.
module csv_field_tokenizer import ct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    // Input stream.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] kind: 0 text byte, 1 end of input
    // Token stream.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] token_byte
    output logic [1:0] m_axis_tuser,   // [1:0] token_kind
    output logic       m_axis_tlast    // last_of_run
);

    // Separator bytes; the user writes them through the configuration port only while idle; not enforced.
    t_cfg r_cfg;

    // Input register: holds one accepted transaction until the result register
    // can take its token list.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;

    t_tok_list toks;
    t_token    out_tok;
    logic      can_load;
    logic      step;

    // The tokenizer advances whenever the held item can be placed in the result
    // register, which is when that register is empty or its last token leaves.
    assign step          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim <= DEFAULT_DELIM;
            r_cfg.quote <= DEFAULT_QUOTE;
            r_cfg.esc   <= DEFAULT_ESCAPE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IDX_DELIM:  r_cfg.delim <= i_cfg_wdata;
                CFG_IDX_QUOTE:  r_cfg.quote <= i_cfg_wdata;
                CFG_IDX_ESCAPE: r_cfg.esc   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // The payload needs no reset; it is only looked at while r_in_valid is set.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    ct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_toks  (toks)
    );

    // An item that yields no token still passes through here; it simply loads
    // an empty list and leaves the output idle.
    ct_tokbuf u_tokbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_toks     (toks),
        .i_tready   (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_token    (out_tok),
        .o_last     (m_axis_tlast),
        .o_can_load (can_load)
    );

    assign m_axis_tdata = out_tok.data;
    assign m_axis_tuser = out_tok.kind;

endmodule
